[rtl/lss_pkg.sv]
package lss_pkg;

  localparam int MAX_STEPS     = 16;
  localparam int DATA_CHANNELS = 4;

  localparam int TPB_W    = 16;
  localparam int STEPS_W  = 7;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 6;
  localparam int CH_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Step address and the width that holds a clamped step count
  localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int SC_W   = $clog2(MAX_STEPS + 1);
  // Loop span is steps times ticks per beat
  localparam int SPAN_W = TPB_W + SC_W;

  // Long division of the time magnitude, one bit a cycle
  localparam int MOD_ITERS = WORD_W;
  localparam int CNT_W     = $clog2(MOD_ITERS);

  localparam logic [TPB_W-1:0]   TPB_RESET   = TPB_W'(24);
  localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(8);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_PITCH  = 2'd1,
    CMD_LENGTH = 2'd2,
    CMD_DATA   = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPB      = 3'd0,
    CFG_STEPS    = 3'd1,
    CFG_OFFSET   = 3'd2,
    CFG_USE_EXT  = 3'd3,
    CFG_USE_GATE = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MOD,
    ST_FIX,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [TPB_W-1:0]   tpb;
    logic [STEPS_W-1:0] steps;
    logic [WORD_W-1:0]  offset;
    logic               use_ext;
    logic               use_gate;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic             latch;
    logic             setup;
    logic             mod_step;
    logic             fix;
    logic             div_step;
    logic [CNT_W-1:0] shift;
    logic             read;
    logic             emit;
  } ctrl_t;

endpackage

[rtl/looping_step_sequencer.sv]
// Channel   Handshake               Carries
// command   start / busy            command, elapsed_ticks, external_time, gate_in,
//                                   step_index, data_channel, write_value
// result    done (one-cycle strobe) pitch_out, data0..3_out, gate_out, current_step
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Write commands are stored at the accepting edge; busy stays low.
// A tick runs from accept to done through one setup state, a bit-serial
// modulo by the loop span, one fixup, a bit-serial step divide, one
// table read and the result state. The modulo loop takes most of the run.
// rst is synchronous; tables read as zero until written.
// The receiver cannot stall; config writes are always taken (cfg_ready high).
module looping_step_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command,
  input  logic [lss_pkg::TPB_W-1:0]       elapsed_ticks,
  input  logic signed [31:0]              external_time,
  input  logic                            gate_in,
  input  logic [lss_pkg::IDX_W-1:0]       step_index,
  input  logic [lss_pkg::CH_W-1:0]        data_channel,
  input  logic signed [31:0]              write_value,
  output logic                            done,
  output logic signed [31:0]              pitch_out,
  output logic signed [31:0]              data0_out,
  output logic signed [31:0]              data1_out,
  output logic signed [31:0]              data2_out,
  output logic signed [31:0]              data3_out,
  output logic                            gate_out,
  output logic [lss_pkg::IDX_W-1:0]       current_step,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import lss_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tpb      <= TPB_RESET;
      cfg.steps    <= STEPS_RESET;
      cfg.offset   <= '0;
      cfg.use_ext  <= 1'b0;
      cfg.use_gate <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TPB:      cfg.tpb      <= cfg_data[TPB_W-1:0];
        CFG_STEPS:    cfg.steps    <= cfg_data[STEPS_W-1:0];
        CFG_OFFSET:   cfg.offset   <= cfg_data;
        CFG_USE_EXT:  cfg.use_ext  <= cfg_data[0];
        CFG_USE_GATE: cfg.use_gate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .ctrl    (ctrl),
    .busy    (busy),
    .done    (done)
  );

  lss_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cfg           (cfg),
    .command       (command),
    .elapsed_ticks (elapsed_ticks),
    .external_time (external_time),
    .gate_in       (gate_in),
    .step_index    (step_index),
    .data_channel  (data_channel),
    .write_value   (write_value),
    .pitch_out     (pitch_out),
    .data0_out     (data0_out),
    .data1_out     (data1_out),
    .data2_out     (data2_out),
    .data3_out     (data3_out),
    .gate_out      (gate_out),
    .current_step  (current_step)
  );

endmodule

[rtl/lss_ctrl.sv]
module lss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          command,
  output lss_pkg::ctrl_t      ctrl,
  output logic                busy,
  output logic                done
);
  import lss_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (start && command == CMD_TICK) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_MOD;
        cnt_next   = CNT_W'(MOD_ITERS - 1);
      end
      ST_MOD: begin
        if (cnt == '0) state_next = ST_FIX;
        else cnt_next = cnt - 1'b1;
      end
      ST_FIX: begin
        state_next = ST_DIV;
        cnt_next   = CNT_W'(STEP_W - 1);
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_READ;
        else cnt_next = cnt - 1'b1;
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl  = '0;
    busy  = 1'b1;
    done  = 1'b0;
    ctrl.shift = cnt;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        // writes finish at the accepting edge
        ctrl.wr_en = start && command != CMD_TICK;
        ctrl.latch = start && command == CMD_TICK;
      end
      ST_SETUP: ctrl.setup    = 1'b1;
      ST_MOD:   ctrl.mod_step = 1'b1;
      ST_FIX:   ctrl.fix      = 1'b1;
      ST_DIV:   ctrl.div_step = 1'b1;
      ST_READ:  ctrl.read     = 1'b1;
      ST_EMIT: begin
        ctrl.emit = 1'b1;
        done      = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

[rtl/lss_dp.sv]
module lss_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  lss_pkg::ctrl_t               ctrl,
  input  lss_pkg::cfg_t                cfg,
  input  logic [1:0]                   command,
  input  logic [lss_pkg::TPB_W-1:0]    elapsed_ticks,
  input  logic signed [31:0]           external_time,
  input  logic                         gate_in,
  input  logic [lss_pkg::IDX_W-1:0]    step_index,
  input  logic [lss_pkg::CH_W-1:0]     data_channel,
  input  logic signed [31:0]           write_value,
  output logic signed [31:0]           pitch_out,
  output logic signed [31:0]           data0_out,
  output logic signed [31:0]           data1_out,
  output logic signed [31:0]           data2_out,
  output logic signed [31:0]           data3_out,
  output logic                         gate_out,
  output logic [lss_pkg::IDX_W-1:0]    current_step
);
  import lss_pkg::*;

  // step tables
  logic [WORD_W-1:0]    pitch_mem [MAX_STEPS];
  logic [WORD_W-1:0]    len_mem   [MAX_STEPS];
  logic [WORD_W-1:0]    data_mem  [DATA_CHANNELS][MAX_STEPS];
  logic [MAX_STEPS-1:0] pitch_vld;
  logic [MAX_STEPS-1:0] len_vld;
  logic [MAX_STEPS-1:0] data_vld  [DATA_CHANNELS];

  logic [WORD_W-1:0] time_counter;
  logic [WORD_W-1:0] t_sum;
  logic [TPB_W-1:0]  elapsed_lat;
  logic              gate_lat;
  logic              neg;
  logic [WORD_W-1:0] mag;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] acc;
  logic [STEP_W-1:0] q;

  logic [WORD_W-1:0] pitch_rd, len_rd;
  logic [WORD_W-1:0] data_rd [DATA_CHANNELS];
  logic [STEP_W-1:0] step_rd;

  logic              wr_ok;
  logic [STEP_W-1:0] wr_addr;
  logic [TPB_W-1:0]  tpb_eff;
  logic [SC_W-1:0]   steps_eff;
  logic [SPAN_W:0]   acc_sh;
  logic [SPAN_W-1:0] dvs;
  logic [STEP_W-1:0] rd_addr;

  assign wr_ok   = ctrl.wr_en && ({1'b0, step_index} < (IDX_W + 1)'(MAX_STEPS));
  assign wr_addr = step_index[STEP_W-1:0];

  assign tpb_eff = (cfg.tpb == '0) ? TPB_W'(1) : cfg.tpb;

  always_comb begin
    if (cfg.steps == '0)
      steps_eff = SC_W'(1);
    else if (cfg.steps > STEPS_W'(MAX_STEPS))
      steps_eff = SC_W'(MAX_STEPS);
    else
      steps_eff = cfg.steps[SC_W-1:0];
  end

  assign acc_sh  = {acc, mag[WORD_W-1]};
  assign dvs     = SPAN_W'(tpb_eff) << ctrl.shift;
  assign rd_addr = ({1'b0, q} >= (STEP_W + 1)'(MAX_STEPS)) ? STEP_W'(MAX_STEPS - 1) : q;

  // table storage
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      case (command)
        CMD_PITCH:  pitch_mem[wr_addr] <= write_value;
        CMD_LENGTH: len_mem[wr_addr]   <= write_value;
        CMD_DATA:   data_mem[data_channel][wr_addr] <= write_value;
        default: ;
      endcase
    end
    if (ctrl.read) begin
      pitch_rd <= pitch_vld[rd_addr] ? pitch_mem[rd_addr] : '0;
      len_rd   <= len_vld[rd_addr] ? len_mem[rd_addr] : '0;
      for (int c = 0; c < DATA_CHANNELS; c++) begin
        data_rd[c] <= data_vld[c][rd_addr] ? data_mem[c][rd_addr] : '0;
      end
      step_rd <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_vld <= '0;
      len_vld   <= '0;
      for (int c = 0; c < DATA_CHANNELS; c++) data_vld[c] <= '0;
    end else if (wr_ok) begin
      case (command)
        CMD_PITCH:  pitch_vld[wr_addr] <= 1'b1;
        CMD_LENGTH: len_vld[wr_addr]   <= 1'b1;
        CMD_DATA:   data_vld[data_channel][wr_addr] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_counter <= '0;
    end else if (ctrl.emit) begin
      time_counter <= time_counter + WORD_W'(elapsed_lat);
    end
  end

  // position and step arithmetic
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      t_sum       <= (cfg.use_ext ? external_time : time_counter) + cfg.offset;
      gate_lat    <= gate_in;
      elapsed_lat <= elapsed_ticks;
    end
    if (ctrl.setup) begin
      span <= SPAN_W'(steps_eff) * SPAN_W'(tpb_eff);
      neg  <= t_sum[WORD_W-1];
      mag  <= t_sum[WORD_W-1] ? (~t_sum + 1'b1) : t_sum;
      acc  <= '0;
    end
    if (ctrl.mod_step) begin
      mag <= mag << 1;
      if (acc_sh >= {1'b0, span})
        acc <= SPAN_W'(acc_sh - {1'b0, span});
      else
        acc <= acc_sh[SPAN_W-1:0];
    end
    if (ctrl.fix) begin
      // floor the remainder for negative time
      if (neg && acc != '0) acc <= span - acc;
      q <= '0;
    end
    if (ctrl.div_step) begin
      if (acc >= dvs) begin
        acc <= acc - dvs;
        q   <= STEP_W'({q, 1'b1});
      end else begin
        q   <= STEP_W'({q, 1'b0});
      end
    end
  end

  assign pitch_out    = pitch_rd;
  assign data0_out    = data_rd[0];
  assign data1_out    = data_rd[1];
  assign data2_out    = data_rd[2];
  assign data3_out    = data_rd[3];
  assign current_step = IDX_W'(step_rd);
  assign gate_out     = !len_rd[WORD_W-1] && (WORD_W'(acc) < len_rd)
                        && (!cfg.use_gate || gate_lat);

endmodule
